// ===== src/sphd_pkg.sv =====
// Shared types and field positions for the superpixel packet hit decoder.
// No dependencies; imported by every module of the block.
package sphd_pkg;

  localparam int unsigned WORD_GROUP_W = 64;
  localparam int unsigned PKT_W        = 48;
  localparam int unsigned NUM_PKT      = 4;
  localparam int unsigned MAP_W        = 8;
  localparam int unsigned BX_W         = 9;
  localparam int unsigned SPCOL_W      = 7;
  localparam int unsigned SPROW_W      = 6;
  localparam int unsigned FT_W         = 14;
  localparam int unsigned PHASE_W      = 4;
  localparam int unsigned PIX_W        = 8;
  localparam int unsigned SLOT_W       = 2;
  localparam int unsigned HIT_W        = NUM_PKT * MAP_W;
  localparam int unsigned HIT_IDX_W    = 5;

  // Bit positions inside one 48-bit packet
  localparam int unsigned MAP_LSB   = 0;
  localparam int unsigned BX_LSB    = 8;
  localparam int unsigned SPROW_LSB = 17;
  localparam int unsigned SPCOL_LSB = 23;

  // Phase steps at or below this value need the extra one-bunch correction
  localparam logic [PHASE_W-1:0] PHASE_EARLY_MAX = 4'd3;

  typedef struct packed {
    logic [MAP_W-1:0]   hit_map;
    logic [BX_W-1:0]    bunch_id;
    logic [SPCOL_W-1:0] spcol;
    logic [SPROW_W-1:0] sprow;
    logic [FT_W-1:0]    fine_time;
  } pkt_t;

  typedef struct packed {
    pkt_t [NUM_PKT-1:0] pkt;
  } word_entry_t;

endpackage

// ===== src/sphd_front.sv =====
// Front stage: accepts link words, cuts them into packets and decodes fields.
// Words without any hit are dropped here. Depends on sphd_pkg.
module sphd_front import sphd_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [PHASE_W-1:0]      phase,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [WORD_GROUP_W-1:0] in_link_word_low,
  input  logic [WORD_GROUP_W-1:0] in_link_word_mid,
  input  logic [WORD_GROUP_W-1:0] in_link_word_high,
  output logic                    f_valid,
  input  logic                    f_ready,
  output word_entry_t             f_entry
);

  logic [3*WORD_GROUP_W-1:0] word;
  logic [PKT_W-1:0]          raw [NUM_PKT];
  word_entry_t               entry;
  logic                      has_hits;
  logic [FT_W-1:0]           ft_offset;
  logic                      vld_r, vld_nxt;
  word_entry_t               entry_r;

  assign word = {in_link_word_high, in_link_word_mid, in_link_word_low};

  // 15 - phase is the bitwise inverse of the 4-bit phase
  always_comb begin
    ft_offset = {{(FT_W-PHASE_W){1'b0}}, ~phase};
    if (phase <= PHASE_EARLY_MAX) begin
      ft_offset = ft_offset - FT_W'(16);
    end
  end

  always_comb begin
    has_hits = 1'b0;
    for (int i = 0; i < NUM_PKT; i++) begin
      raw[i] = word[i*PKT_W +: PKT_W];
      entry.pkt[i].hit_map   = raw[i][MAP_LSB +: MAP_W];
      entry.pkt[i].bunch_id  = raw[i][BX_LSB +: BX_W];
      entry.pkt[i].sprow     = raw[i][SPROW_LSB +: SPROW_W];
      entry.pkt[i].spcol     = raw[i][SPCOL_LSB +: SPCOL_W];
      entry.pkt[i].fine_time = {raw[i][BX_LSB +: BX_W], 4'b0000} + ft_offset;
      has_hits = has_hits | (|raw[i][MAP_LSB +: MAP_W]);
    end
  end

  assign in_ready = !vld_r || f_ready;

  always_comb begin
    vld_nxt = vld_r;
    if (in_valid && in_ready) begin
      vld_nxt = has_hits;
    end else if (f_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      entry_r <= entry;
    end
  end

  assign f_valid = vld_r;
  assign f_entry = entry_r;

endmodule

// ===== src/sphd_fifo.sv =====
// Short queue of decoded words between the front and back stages.
// Depends on sphd_pkg for the entry type.
module sphd_fifo import sphd_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push_valid,
  output logic        push_ready,
  input  word_entry_t push_data,
  output logic        pop_valid,
  input  logic        pop_ready,
  output word_entry_t pop_data
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  word_entry_t      mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push, pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== src/sphd_back.sv =====
// Back stage: walks the hit bits of one decoded word, one hit per beat,
// into a registered output. Depends on sphd_pkg.
module sphd_back import sphd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_ready,
  input  word_entry_t        q_entry,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [PIX_W-1:0]   out_pixel_column,
  output logic [PIX_W-1:0]   out_pixel_row,
  output logic [BX_W-1:0]    out_bunch_id,
  output logic signed [FT_W-1:0] out_fine_time,
  output logic [SLOT_W-1:0]  out_packet_slot,
  output logic               out_last_hit
);

  word_entry_t          cur_r;
  logic [HIT_W-1:0]     mask_r, mask_nxt;
  logic [HIT_W-1:0]     q_mask;
  logic [HIT_W-1:0]     pick_oh;
  logic [HIT_W-1:0]     mask_left;
  logic [HIT_IDX_W-1:0] pick_idx;
  logic                 busy, advance, emit, last, load;
  logic                 out_valid_r, out_valid_nxt;
  pkt_t                 pkt_sel;
  logic [2:0]           j;

  always_comb begin
    for (int i = 0; i < NUM_PKT; i++) begin
      q_mask[i*MAP_W +: MAP_W] = q_entry.pkt[i].hit_map;
    end
  end

  // Lowest set bit first: packet order, then ascending map bit
  always_comb begin
    pick_idx = '0;
    for (int i = HIT_W - 1; i >= 0; i--) begin
      if (mask_r[i]) begin
        pick_idx = HIT_IDX_W'(i);
      end
    end
  end

  assign pick_oh   = HIT_W'(1) << pick_idx;
  assign mask_left = mask_r & ~pick_oh;
  assign busy      = |mask_r;
  assign advance   = !out_valid_r || out_ready;
  assign emit      = busy && advance;
  assign last      = (mask_left == '0);
  assign load      = q_valid && (!busy || (emit && last));
  assign q_ready   = !busy || (emit && last);

  always_comb begin
    mask_nxt = mask_r;
    if (emit) begin
      mask_nxt = mask_left;
    end
    if (load) begin
      mask_nxt = q_mask;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = busy;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mask_r      <= mask_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_r <= q_entry;
    end
  end

  assign pkt_sel = cur_r.pkt[pick_idx[HIT_IDX_W-1:3]];
  assign j       = pick_idx[2:0];

  // Column is 2*spcol + j/4 and row is 4*sprow + j%4: plain concatenations
  always_ff @(posedge clk) begin
    if (emit) begin
      out_pixel_column <= {pkt_sel.spcol, j[2]};
      out_pixel_row    <= {pkt_sel.sprow, j[1:0]};
      out_bunch_id     <= pkt_sel.bunch_id;
      out_fine_time    <= pkt_sel.fine_time;
      out_packet_slot  <= pick_idx[HIT_IDX_W-1:3];
      out_last_hit     <= last;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== src/superpixel_packet_hit_decoder.sv =====
// Superpixel packet hit decoder: link word in, one pixel hit per output beat.
// Path: front register, queue, back-stage mask and output regs. Throughput: one
// hit per cycle while out_ready allows; a word holds the back stage until its
// last hit. Words are taken every cycle while the QUEUE_DEPTH queue has room.
// Reset (synchronous, rst_n low) empties front, queue and output; phase is 0.
// Depends on sphd_pkg, sphd_front, sphd_fifo and sphd_back.
module superpixel_packet_hit_decoder import sphd_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_wr_en,
  input  logic [PHASE_W-1:0]      cfg_wr_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [WORD_GROUP_W-1:0] in_link_word_low,
  input  logic [WORD_GROUP_W-1:0] in_link_word_mid,
  input  logic [WORD_GROUP_W-1:0] in_link_word_high,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [PIX_W-1:0]        out_pixel_column,
  output logic [PIX_W-1:0]        out_pixel_row,
  output logic [BX_W-1:0]         out_bunch_id,
  output logic signed [FT_W-1:0]  out_fine_time,
  output logic [SLOT_W-1:0]       out_packet_slot,
  output logic                    out_last_hit
);

  logic [PHASE_W-1:0] phase_r;
  logic               f_valid, f_ready;
  word_entry_t        f_entry;
  logic               q_valid, q_ready;
  word_entry_t        q_entry;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
    end else if (cfg_wr_en) begin
      phase_r <= cfg_wr_data;
    end
  end

  sphd_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .phase             (phase_r),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_link_word_low  (in_link_word_low),
    .in_link_word_mid  (in_link_word_mid),
    .in_link_word_high (in_link_word_high),
    .f_valid           (f_valid),
    .f_ready           (f_ready),
    .f_entry           (f_entry)
  );

  sphd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_entry),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_entry)
  );

  sphd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_ready          (q_ready),
    .q_entry          (q_entry),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pixel_column (out_pixel_column),
    .out_pixel_row    (out_pixel_row),
    .out_bunch_id     (out_bunch_id),
    .out_fine_time    (out_fine_time),
    .out_packet_slot  (out_packet_slot),
    .out_last_hit     (out_last_hit)
  );

  // A word of all zeros carries no hits and must never reach the queue
  a_zero_word_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_link_word_low == '0) && (in_link_word_mid == '0) &&
    (in_link_word_high == '0) |=> !f_valid)
    else $error("all-zero link word passed the front stage");

  // Front must hold a decoded word while the queue is full
  a_front_holds: assert property (@(posedge clk) disable iff (!rst_n)
    f_valid && !f_ready |=> f_valid && $stable(f_entry))
    else $error("front stage lost a word while the queue was full");

  // Reset leaves no result pending
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule
